>>> sv/keypad_gesture_decoder_macros.svh
// Assertion macros shared by the gesture decoder's checker.
`ifndef KEYPAD_GESTURE_DECODER_MACROS_SVH
`define KEYPAD_GESTURE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KGD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KGD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/kgd_pkg.sv
// Shared types and constants of the keypad gesture decoder.
package kgd_pkg;

  // Command codes of a result item.
  localparam logic [3:0] CMD_NONE   = 4'd0;
  localparam logic [3:0] CMD_CLICK  = 4'd1;
  localparam logic [3:0] CMD_RESUME = 4'd2;
  localparam logic [3:0] CMD_PAUSE  = 4'd3;
  localparam logic [3:0] CMD_OFF    = 4'd4;
  localparam logic [3:0] CMD_LOCK   = 4'd5;
  localparam logic [3:0] CMD_TONE   = 4'd6;
  localparam logic [3:0] CMD_VUP    = 4'd7;
  localparam logic [3:0] CMD_VDN    = 4'd8;
  localparam logic [3:0] CMD_SEEK   = 4'd9;
  localparam logic [3:0] CMD_NEXT   = 4'd10;
  localparam logic [3:0] CMD_PREV   = 4'd11;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SKIP_CONT  = 2'd0;
  localparam logic [1:0] CFG_SKIP_SECS  = 2'd1;
  localparam logic [1:0] CFG_CLICK_EN   = 2'd2;
  localparam logic [1:0] CFG_TONE_EN    = 2'd3;

  // Port widths.
  localparam int IN_W   = 104;
  localparam int USER_W = 2;
  localparam int OUT_W  = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Most tones one event can produce.
  localparam int MAX_TONES_PER_EVENT = 4;

  // Configuration as seen by the front end.
  typedef struct packed {
    logic       skip_cont;
    logic [3:0] skip_secs;
    logic       click_en;
    logic       tone_en;
  } cfg_t;

  // Run descriptor: one per event, expanded into result items by the back end.
  // Run order is optional click, then tones, then the main command.
  typedef struct packed {
    logic        handled;
    logic        click;
    logic [2:0]  tone_cnt;
    logic [2:0]  tone_step;
    logic        tone_rising;
    logic [3:0]  main_cmd;
    logic [30:0] main_value;
    logic        lock_before;
    logic        lock_after;
  } desc_t;

endpackage

>>> sv/kgd_front.sv
// Front end: accepts key events, keeps the gesture state and builds run descriptors.
module kgd_front
  import kgd_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 100,
  parameter int SEEK_STEP_MS     = 5000,
  parameter int TONE_NOTES       = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic [USER_W-1:0] in_tuser,
  input  logic              q_ready,
  output logic              q_push,
  output desc_t             q_data
);

  localparam int T_LOCK  = TICKS_PER_SECOND;
  localparam int T_OFF   = 4 * TICKS_PER_SECOND;
  localparam int T_TAP   = TICKS_PER_SECOND * 300 / 1000;
  localparam int T_SKIP  = TICKS_PER_SECOND * 3 / 10;
  localparam int T_VREP  = TICKS_PER_SECOND / 20;
  localparam int T_VDLY  = TICKS_PER_SECOND / 4;
  localparam int T_CHAIN = 2 * TICKS_PER_SECOND;
  localparam int SPAN    = (T_LOCK - T_TAP) > 0 ? (T_LOCK - T_TAP) : 1;
  localparam int HW      = $clog2(T_OFF + 1);
  localparam int PW      = HW + 3;
  localparam logic [30:0] MS_MAX = 31'h7FFF_FFFF;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_EVAL = 1'b1;

  logic state_r, state_nxt;

  // Captured event.
  logic [4:0]  key_r;
  logic        rep_r, rel_r, play_r, pause_r, track_r;
  logic [31:0] now_r;
  logic [30:0] elap_r, len_r;

  // Gesture state.
  logic        lock_r, lock_nxt;
  logic        pheld_r, pheld_nxt;
  logic        pused_r, pused_nxt;
  logic        fired_r, fired_nxt;
  logic [2:0]  tc_r, tc_nxt;
  logic [31:0] ptick_r, ptick_nxt;
  logic        vpend_r, vpend_nxt;
  logic [31:0] vdue_r, vdue_nxt;
  logic        chain_r, chain_nxt;
  logic [30:0] gms_r, gms_nxt;
  logic [31:0] gtick_r, gtick_nxt;
  logic [1:0]  sheld_r, sheld_nxt;
  logic [1:0]  sdone_r, sdone_nxt;
  logic [1:0]  shap_r, shap_nxt;
  logic [31:0] stick_r [2];
  logic [31:0] stick_nxt [2];

  logic        eval_go;
  logic        both_vol;
  logic        sk;
  logic signed [31:0] h_pow, h_vol, h_skip, h_chain;
  logic [31:0] thr;
  logic [HW-1:0] x_h;
  logic [PW-1:0] prod;
  logic [2:0]  want, tone_n;
  logic signed [32:0] base, pos;
  logic [30:0] seek_pos;
  logic        seek_chain;
  desc_t       d;

  assign in_tready = (state_r == F_IDLE);
  assign eval_go   = (state_r == F_EVAL) && q_ready;
  assign q_push    = eval_go;
  assign q_data    = d;

  // Control state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_tvalid) begin
        state_nxt = F_EVAL;
      end
      F_EVAL: if (q_ready) begin
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Time differences, read as signed 32-bit.
  assign both_vol = key_r[1] && key_r[2];
  assign sk       = ~key_r[3];
  assign h_pow    = $signed(now_r - ptick_r);
  assign h_vol    = $signed(now_r - vdue_r);
  assign h_skip   = $signed(now_r - stick_r[sk]);
  assign h_chain  = $signed(now_r - (gtick_r + 32'(T_CHAIN)));
  assign thr      = (cfg.skip_cont && shap_r[sk])
                    ? (32'(cfg.skip_secs) * 32'(TICKS_PER_SECOND)) : 32'(T_SKIP);

  // Tones owed: count of note thresholds the hold has passed.
  always_comb begin
    x_h  = h_pow[HW-1:0] - HW'(T_TAP);
    prod = PW'(x_h) * PW'(TONE_NOTES);
    want = 3'd0;
    for (int j = 1; j <= 7; j++) begin
      if (j <= TONE_NOTES && PW'(j * SPAN) <= prod) begin
        want = want + 3'd1;
      end
    end
    if (want > tc_r) begin
      tone_n = ((want - tc_r) > 3'(MAX_TONES_PER_EVENT))
               ? 3'(MAX_TONES_PER_EVENT) : (want - tc_r);
    end else begin
      tone_n = 3'd0;
    end
  end

  // Seek target: chained from the last goal or from the reported position.
  always_comb begin
    seek_chain = chain_r && h_chain[31];
    base = seek_chain ? $signed({2'b00, gms_r}) : $signed({2'b00, elap_r});
    pos  = sk ? (base + 33'sd0 + $signed(33'(SEEK_STEP_MS)))
              : (base - $signed(33'(SEEK_STEP_MS)));
    if (pos[32]) begin
      seek_pos = 31'd0;
    end else if (len_r != 31'd0 && pos[31:0] > {1'b0, len_r}) begin
      seek_pos = len_r;
    end else if (pos[31:0] > {1'b0, MS_MAX}) begin
      seek_pos = MS_MAX;
    end else begin
      seek_pos = pos[30:0];
    end
  end

  // Event handling.
  always_comb begin
    lock_nxt  = lock_r;
    pheld_nxt = pheld_r;
    pused_nxt = pused_r;
    fired_nxt = fired_r;
    tc_nxt    = tc_r;
    ptick_nxt = ptick_r;
    vpend_nxt = vpend_r;
    vdue_nxt  = vdue_r;
    chain_nxt = chain_r;
    gms_nxt   = gms_r;
    gtick_nxt = gtick_r;
    sheld_nxt = sheld_r;
    sdone_nxt = sdone_r;
    shap_nxt  = shap_r;
    stick_nxt[0] = stick_r[0];
    stick_nxt[1] = stick_r[1];

    d.handled     = (key_r != 5'd0);
    d.click       = 1'b0;
    d.tone_cnt    = 3'd0;
    d.tone_step   = tc_r;
    d.tone_rising = lock_r;
    d.main_cmd    = CMD_NONE;
    d.main_value  = 31'd0;
    d.lock_before = lock_r;

    if (key_r == 5'd0 || both_vol) begin
      // No key, or both volume keys: nothing to do.
    end else if (key_r[0]) begin
      if (rel_r) begin
        // Power release: a short press with nothing done is a tap.
        pheld_nxt = 1'b0;
        ptick_nxt = 32'd0;
        fired_nxt = 1'b0;
        tc_nxt    = 3'd0;
        pused_nxt = 1'b0;
        if (!pused_r && (!pheld_r || h_pow < $signed(32'(T_TAP)))) begin
          d.click = cfg.click_en;
          if (pause_r) begin
            d.main_cmd = CMD_RESUME;
          end else if (play_r) begin
            d.main_cmd = CMD_PAUSE;
          end
        end
      end else if (!pheld_r) begin
        pheld_nxt = 1'b1;
        ptick_nxt = now_r;
        pused_nxt = 1'b0;
        fired_nxt = 1'b0;
        tc_nxt    = 3'd0;
      end else if (rep_r) begin
        if (h_pow >= $signed(32'(T_OFF))) begin
          d.click    = cfg.click_en;
          d.main_cmd = CMD_OFF;
          pused_nxt  = 1'b1;
        end else begin
          if (!fired_r && h_pow >= $signed(32'(T_TAP))) begin
            tc_nxt     = tc_r + tone_n;
            d.tone_cnt = cfg.tone_en ? tone_n : 3'd0;
          end
          if (!fired_r && h_pow >= $signed(32'(T_LOCK))) begin
            fired_nxt  = 1'b1;
            pused_nxt  = 1'b1;
            lock_nxt   = ~lock_r;
            d.main_cmd = CMD_LOCK;
          end
        end
      end
    end else if (lock_r) begin
      // Locked: other keys are swallowed.
    end else if (key_r[1] || key_r[2]) begin
      if (rel_r) begin
        vpend_nxt = 1'b0;
        vdue_nxt  = 32'd0;
      end else if (!rep_r) begin
        d.main_cmd = key_r[1] ? CMD_VUP : CMD_VDN;
        vdue_nxt   = now_r + 32'(T_VDLY);
        vpend_nxt  = 1'b1;
      end else if (vpend_r && h_vol > 32'sd0) begin
        d.main_cmd = key_r[1] ? CMD_VUP : CMD_VDN;
        vdue_nxt   = now_r + 32'(T_VREP);
      end
    end else begin
      if (rel_r) begin
        sheld_nxt[sk] = 1'b0;
        stick_nxt[sk] = 32'd0;
        sdone_nxt[sk] = 1'b0;
        shap_nxt[sk]  = 1'b0;
      end else if (!rep_r) begin
        sheld_nxt[sk] = 1'b1;
        stick_nxt[sk] = now_r;
        sdone_nxt[sk] = 1'b0;
        shap_nxt[sk]  = 1'b0;
        if (play_r && track_r) begin
          gms_nxt      = seek_pos;
          gtick_nxt    = now_r;
          chain_nxt    = 1'b1;
          d.main_cmd   = CMD_SEEK;
          d.main_value = seek_pos;
        end
      end else if (sheld_r[sk] && !sdone_r[sk] && h_skip >= $signed(thr)) begin
        shap_nxt[sk] = 1'b1;
        if (cfg.skip_cont) begin
          stick_nxt[sk] = now_r;
        end else begin
          sdone_nxt[sk] = 1'b1;
        end
        d.click    = cfg.click_en;
        chain_nxt  = 1'b0;
        gtick_nxt  = 32'd0;
        d.main_cmd = sk ? CMD_NEXT : CMD_PREV;
      end
    end
    d.lock_after = lock_nxt;
  end

  // Event capture.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r   <= in_tdata[4:0];
      now_r   <= in_tdata[36:5];
      play_r  <= in_tdata[37];
      pause_r <= in_tdata[38];
      track_r <= in_tdata[39];
      elap_r  <= in_tdata[70:40];
      len_r   <= in_tdata[101:71];
      rep_r   <= in_tuser[0];
      rel_r   <= in_tuser[1];
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      lock_r     <= 1'b0;
      pheld_r    <= 1'b0;
      pused_r    <= 1'b0;
      fired_r    <= 1'b0;
      tc_r       <= 3'd0;
      ptick_r    <= 32'd0;
      vpend_r    <= 1'b0;
      vdue_r     <= 32'd0;
      chain_r    <= 1'b0;
      gms_r      <= 31'd0;
      gtick_r    <= 32'd0;
      sheld_r    <= 2'b00;
      sdone_r    <= 2'b00;
      shap_r     <= 2'b00;
      stick_r[0] <= 32'd0;
      stick_r[1] <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (eval_go) begin
        lock_r     <= lock_nxt;
        pheld_r    <= pheld_nxt;
        pused_r    <= pused_nxt;
        fired_r    <= fired_nxt;
        tc_r       <= tc_nxt;
        ptick_r    <= ptick_nxt;
        vpend_r    <= vpend_nxt;
        vdue_r     <= vdue_nxt;
        chain_r    <= chain_nxt;
        gms_r      <= gms_nxt;
        gtick_r    <= gtick_nxt;
        sheld_r    <= sheld_nxt;
        sdone_r    <= sdone_nxt;
        shap_r     <= shap_nxt;
        stick_r[0] <= stick_nxt[0];
        stick_r[1] <= stick_nxt[1];
      end
    end
  end

endmodule

>>> sv/kgd_queue.sv
// Two-entry queue of run descriptors between the front and back ends.
module kgd_queue
  import kgd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_data,
  output logic  ready,
  input  logic  pop,
  output logic  valid,
  output desc_t head
);

  desc_t      ent_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign ready   = (cnt_r != 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign head    = ent_r[rd_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_r] <= push_data;
    end
  end

endmodule

>>> sv/kgd_back.sv
// Back end: expands run descriptors into result items behind an output register.
module kgd_back
  import kgd_pkg::*;
#(
  parameter int TONE_NOTES = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  desc_t            q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  localparam int TONE_LO = 700;
  localparam int TONE_HI = 1500;
  localparam int TOTAL   = TONE_NOTES < 2 ? 2 : TONE_NOTES;

  logic [10:0] rise_tab [8];
  logic [10:0] fall_tab [8];

  // Tone frequency tables, one entry per note step.
  for (genvar g = 0; g < 8; g++) begin : g_tone
    localparam int STEP = (g > TOTAL - 1) ? (TOTAL - 1) : g;
    localparam int HZ   = TONE_LO + (TONE_HI - TONE_LO) * STEP / (TOTAL - 1);
    assign rise_tab[g] = 11'(HZ);
    assign fall_tab[g] = 11'(TONE_LO + TONE_HI - HZ);
  end

  desc_t       desc_r;
  logic        busy_r, busy_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [OUT_W-1:0] odata_r;
  logic        olast_r;

  logic        emit_go;
  logic [2:0]  n_items, off, step;
  logic [3:0]  it_cmd;
  logic [30:0] it_val;
  logic        it_lock, it_last;

  assign q_pop      = !busy_r && q_valid;
  assign emit_go    = busy_r && (!ovalid_r || out_tready);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  // Current item of the run.
  always_comb begin
    n_items = 3'(desc_r.click) + desc_r.tone_cnt + 3'(desc_r.main_cmd != CMD_NONE);
    if (n_items == 3'd0) begin
      n_items = 3'd1;
    end
    off  = idx_r - 3'(desc_r.click);
    step = desc_r.tone_step + off;
    if (desc_r.click && idx_r == 3'd0) begin
      it_cmd  = CMD_CLICK;
      it_val  = 31'd0;
      it_lock = desc_r.lock_before;
    end else if (off < desc_r.tone_cnt) begin
      it_cmd  = CMD_TONE;
      it_val  = 31'(desc_r.tone_rising ? rise_tab[step] : fall_tab[step]);
      it_lock = desc_r.lock_before;
    end else begin
      it_cmd  = desc_r.main_cmd;
      it_val  = desc_r.main_value;
      it_lock = desc_r.lock_after;
    end
    it_last = (idx_r == n_items - 3'd1);
  end

  // Run sequencing.
  always_comb begin
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end
    if (emit_go) begin
      idx_nxt = idx_r + 3'd1;
      if (it_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (emit_go) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      idx_r    <= 3'd0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Descriptor and output payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_head;
    end
    if (emit_go) begin
      odata_r <= {3'b000, it_lock, it_val, it_cmd, desc_r.handled};
      olast_r <= it_last;
    end
  end

endmodule

>>> sv/keypad_gesture_decoder.sv
// Top level of the keypad gesture decoder: configuration registers and the front/back pipeline.
//
// Usage: each key event enters on the in_ stream (in_tdata carries key mask, tick stamp,
// playback status and track position; in_tuser carries the repeat and release flags).
// Every event yields a run of one to five command items on the out_ stream, the final
// item of the run marked by out_tlast. Configuration registers are written on the cfg_
// channel, which is always ready; write it only while no event is in progress.
// An event is registered in the front end, queued as a descriptor, loaded into the back
// end's descriptor register, and its items are then registered at the output. The front
// end takes a new event only once the last descriptor has entered its two-entry queue;
// the back end takes the next descriptor only after emitting the last item of a run.
// Reset (rst_n low at a clock edge) unlocks the keys, forgets all held keys, the
// volume repeat and the seek chain, and restores the register defaults.
// When the receiver stalls, the output register holds its item; the back end and
// then the queue fill, after which in_tready stays low until items drain.
module keypad_gesture_decoder
  import kgd_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 100,
  parameter int SEEK_STEP_MS     = 5000,
  parameter int TONE_NOTES       = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Event stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // key_mask[4:0], now_tick[36:5], is_playing[37], is_paused[38], has_track[39],
  // elapsed_ms[70:40], track_length_ms[101:71], zero fill [103:102]
  input  logic [IN_W-1:0]       in_tdata,
  // is_repeat[0], is_release[1]
  input  logic [USER_W-1:0]     in_tuser,
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // handled[0], command[4:1], value[35:5], lock_state[36], zero fill [39:37]
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tlast,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  logic  q_push, q_ready, q_pop, q_valid;
  desc_t q_in, q_head;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.skip_cont <= 1'b0;
      cfg_r.skip_secs <= 4'd3;
      cfg_r.click_en  <= 1'b1;
      cfg_r.tone_en   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SKIP_CONT: cfg_r.skip_cont <= cfg_data[0];
        CFG_SKIP_SECS: cfg_r.skip_secs <= cfg_data;
        CFG_CLICK_EN:  cfg_r.click_en  <= cfg_data[0];
        CFG_TONE_EN:   cfg_r.tone_en   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  kgd_front #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .SEEK_STEP_MS     (SEEK_STEP_MS),
    .TONE_NOTES       (TONE_NOTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  kgd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  kgd_back #(
    .TONE_NOTES (TONE_NOTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sv/kgd_checker.sv
// Port-level checks of the gesture decoder's result stream, bound to the top level.
`include "keypad_gesture_decoder_macros.svh"

module kgd_checker
  import kgd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);

  logic [3:0]  cmd;
  logic [30:0] val;

  assign cmd = out_tdata[4:1];
  assign val = out_tdata[35:5];

  // A stalled item stays put.
  `KGD_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result item changed")

  // Only defined command codes leave the block.
  `KGD_ASSERT_NOW(a_cmd_code, out_tvalid, cmd <= CMD_PREV, "undefined command code")

  // Only seek and tone items carry a value.
  `KGD_ASSERT_NOW(a_value_zero, out_tvalid && cmd != CMD_SEEK && cmd != CMD_TONE, val == 31'd0, "value set on a command that has none")

  // An unhandled event gives a single empty item.
  `KGD_ASSERT_NOW(a_unhandled, out_tvalid && !out_tdata[0], out_tlast && cmd == CMD_NONE, "unhandled event produced a command")

endmodule

bind keypad_gesture_decoder kgd_checker u_kgd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> tb/keypad_gesture_decoder_checker.sv
// Checker for the keypad gesture decoder: predicts each command run and compares result items.
`timescale 1ns / 100ps

module keypad_gesture_decoder_checker
  import kgd_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 100,
  parameter int SEEK_STEP_MS     = 5000,
  parameter int TONE_NOTES       = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  input  logic [USER_W-1:0]     in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_W-1:0]      out_tdata,
  input  logic                  out_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_count,
  output int                    result_count
);

  // Gesture timing in ticks.
  localparam int T_LOCK     = TICKS_PER_SECOND;
  localparam int T_OFF      = 4 * TICKS_PER_SECOND;
  localparam int T_TAP      = TICKS_PER_SECOND * 300 / 1000;
  localparam int T_SKIP     = TICKS_PER_SECOND * 3 / 10;
  localparam int T_VREP     = TICKS_PER_SECOND / 20;
  localparam int T_VDLY     = TICKS_PER_SECOND / 4;
  localparam int T_CHAIN    = 2 * TICKS_PER_SECOND;
  localparam int T_SPAN     = (T_LOCK - T_TAP > 0) ? (T_LOCK - T_TAP) : 1;
  localparam int TONE_TOTAL = (TONE_NOTES < 2) ? 2 : TONE_NOTES;
  localparam int TONE_LO_HZ = 700;
  localparam int TONE_HI_HZ = 1500;
  localparam int MAX_RUN    = 5;
  localparam longint MS_MAX = 64'h7FFF_FFFF;

  typedef struct packed {
    logic        handled;
    logic [3:0]  command;
    logic [30:0] value;
    logic        lock_state;
    logic        last;
  } cmd_item_t;

  // Register shadow.
  logic       c_cont;
  logic [3:0] c_secs;
  logic       c_click;
  logic       c_tone;

  // Gesture state of the predictor.
  logic        lock_q;
  logic        pwr_held, pwr_used, lock_fired;
  logic [31:0] pwr_tick;
  logic [2:0]  tone_cnt;
  logic        vol_pend;
  logic [31:0] vol_due;
  logic        chain_ok;
  logic [30:0] goal_ms;
  logic [31:0] goal_tick;
  logic        skip_held [2];
  logic        skip_done [2];
  logic        skip_seen [2];
  logic [31:0] skip_tick [2];

  logic [31:0] ev_tick;
  logic        ev_handled;
  cmd_item_t   run_buf [MAX_RUN];
  int          run_n;
  cmd_item_t   exp_q [$];
  int          mismatches = 0;
  int          results_seen = 0;

  // Tick difference read as a signed 32-bit value.
  function automatic longint tick_diff(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return longint'($signed(d));
  endfunction

  // Appends one command to the run being built, dropping any past the run limit.
  task automatic add_result(input logic [3:0] cmd, input logic [30:0] val);
    if (run_n < MAX_RUN) begin
      run_buf[run_n] = {ev_handled, cmd, val, lock_q, 1'b0};
      run_n++;
    end
  endtask

  // Works out the command run of one key event and queues it.
  task automatic predict_run(input logic [IN_W-1:0] d, input logic [USER_W-1:0] u);
    logic [4:0]  keys;
    logic        rep, rel, playing, paused, track, tap, fwd;
    logic [30:0] elapsed, length;
    logic [3:0]  cmd;
    longint      h, want, pos, thr;
    int          sent, k, step, hz, i;
    cmd_item_t   r;
    keys    = d[4:0];
    ev_tick = d[36:5];
    playing = d[37];
    paused  = d[38];
    track   = d[39];
    elapsed = d[70:40];
    length  = d[101:71];
    rep     = u[0];
    rel     = u[1];
    ev_handled = (keys != 5'd0);
    run_n = 0;

    if (keys == 5'd0 || (keys[1] && keys[2])) begin
      // No key, or both volume keys: nothing to do.
    end else if (keys[0]) begin
      // Power key: tap, lock hold with arming tones, power-off hold.
      if (rel) begin
        h = pwr_held ? tick_diff(ev_tick, pwr_tick) : 0;
        tap = !pwr_used && h < T_TAP;
        pwr_held   = 1'b0;
        pwr_tick   = '0;
        lock_fired = 1'b0;
        tone_cnt   = '0;
        pwr_used   = 1'b0;
        if (tap) begin
          if (c_click) add_result(CMD_CLICK, '0);
          if (paused) add_result(CMD_RESUME, '0);
          else if (playing) add_result(CMD_PAUSE, '0);
        end
      end else if (!pwr_held) begin
        pwr_held   = 1'b1;
        pwr_tick   = ev_tick;
        pwr_used   = 1'b0;
        lock_fired = 1'b0;
        tone_cnt   = '0;
      end else if (rep) begin
        h = tick_diff(ev_tick, pwr_tick);
        if (h >= T_OFF) begin
          if (c_click) add_result(CMD_CLICK, '0);
          add_result(CMD_OFF, '0);
          pwr_used = 1'b1;
        end else begin
          if (!lock_fired && h >= T_TAP) begin
            want = (h - T_TAP) * TONE_NOTES / T_SPAN;
            if (want > TONE_NOTES) want = TONE_NOTES;
            sent = 0;
            while (longint'(tone_cnt) < want && sent < MAX_TONES_PER_EVENT) begin
              if (c_tone) begin
                step = (tone_cnt > TONE_TOTAL - 1) ? TONE_TOTAL - 1 : int'(tone_cnt);
                hz = TONE_LO_HZ + (TONE_HI_HZ - TONE_LO_HZ) * step / (TONE_TOTAL - 1);
                // Rising tones when unlocking, falling when locking.
                if (!lock_q) hz = TONE_LO_HZ + TONE_HI_HZ - hz;
                add_result(CMD_TONE, hz[30:0]);
              end
              tone_cnt = tone_cnt + 3'd1;
              sent++;
            end
          end
          if (h >= T_LOCK && !lock_fired) begin
            lock_fired = 1'b1;
            pwr_used   = 1'b1;
            lock_q     = !lock_q;
            add_result(CMD_LOCK, '0);
          end
        end
      end
    end else if (lock_q) begin
      // Locked: other keys are swallowed.
    end else if (keys[1] || keys[2]) begin
      // Volume: one step on press, then autorepeat after the initial delay.
      cmd = keys[1] ? CMD_VUP : CMD_VDN;
      if (rel) begin
        vol_pend = 1'b0;
        vol_due  = '0;
      end else if (!rep) begin
        add_result(cmd, '0);
        vol_due  = ev_tick + T_VDLY;
        vol_pend = 1'b1;
      end else if (vol_pend && tick_diff(ev_tick, vol_due) > 0) begin
        add_result(cmd, '0);
        vol_due = ev_tick + T_VREP;
      end
    end else begin
      // Skip keys: seek on press, track change on hold.
      fwd = !keys[3];
      k = keys[3] ? 0 : 1;
      if (rel) begin
        skip_held[k] = 1'b0;
        skip_tick[k] = '0;
        skip_done[k] = 1'b0;
        skip_seen[k] = 1'b0;
      end else if (!rep) begin
        skip_held[k] = 1'b1;
        skip_tick[k] = ev_tick;
        skip_done[k] = 1'b0;
        skip_seen[k] = 1'b0;
        if (playing && track) begin
          if (chain_ok && tick_diff(ev_tick, goal_tick + T_CHAIN) < 0) pos = longint'(goal_ms);
          else pos = longint'(elapsed);
          pos = fwd ? pos + SEEK_STEP_MS : pos - SEEK_STEP_MS;
          if (pos < 0) pos = 0;
          if (length != '0 && pos > longint'(length)) pos = longint'(length);
          if (pos > MS_MAX) pos = MS_MAX;
          goal_ms   = pos[30:0];
          goal_tick = ev_tick;
          chain_ok  = 1'b1;
          add_result(CMD_SEEK, pos[30:0]);
        end
      end else begin
        thr = (c_cont && skip_seen[k]) ? longint'(c_secs) * TICKS_PER_SECOND : T_SKIP;
        if (skip_held[k] && !skip_done[k] && tick_diff(ev_tick, skip_tick[k]) >= thr) begin
          skip_seen[k] = 1'b1;
          if (c_cont) skip_tick[k] = ev_tick;
          else skip_done[k] = 1'b1;
          if (c_click) add_result(CMD_CLICK, '0);
          chain_ok  = 1'b0;
          goal_tick = '0;
          add_result(fwd ? CMD_NEXT : CMD_PREV, '0);
        end
      end
    end

    if (run_n == 0) add_result(CMD_NONE, '0);
    for (i = 0; i < run_n; i++) begin
      r = run_buf[i];
      if (i == run_n - 1) r.last = 1'b1;
      exp_q.push_back(r);
    end
  endtask

  // Results are checked before a new event is predicted at the same edge.
  always @(posedge clk) begin
    cmd_item_t got, want_r;
    if (!rst_n) begin
      c_cont     = 1'b0;
      c_secs     = 4'd3;
      c_click    = 1'b1;
      c_tone     = 1'b1;
      lock_q     = 1'b0;
      pwr_held   = 1'b0;
      pwr_used   = 1'b0;
      lock_fired = 1'b0;
      pwr_tick   = '0;
      tone_cnt   = '0;
      vol_pend   = 1'b0;
      vol_due    = '0;
      chain_ok   = 1'b0;
      goal_ms    = '0;
      goal_tick  = '0;
      for (int j = 0; j < 2; j++) begin
        skip_held[j] = 1'b0;
        skip_done[j] = 1'b0;
        skip_seen[j] = 1'b0;
        skip_tick[j] = '0;
      end
      exp_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[4:1], out_tdata[35:5], out_tdata[36], out_tlast};
        results_seen++;
        if (exp_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result item: handled=%0d cmd=%0d value=%0d lock=%0d last=%0d",
                     got.handled, got.command, got.value, got.lock_state, got.last);
          mismatches++;
        end else begin
          want_r = exp_q.pop_front();
          if (got !== want_r) begin
            if (mismatches < 10)
              $display("result %0d mismatch: expected handled=%0d cmd=%0d value=%0d lock=%0d last=%0d, got handled=%0d cmd=%0d value=%0d lock=%0d last=%0d",
                       results_seen, want_r.handled, want_r.command, want_r.value,
                       want_r.lock_state, want_r.last, got.handled, got.command,
                       got.value, got.lock_state, got.last);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SKIP_CONT: c_cont  = cfg_data[0];
          CFG_SKIP_SECS: c_secs  = cfg_data;
          CFG_CLICK_EN:  c_click = cfg_data[0];
          CFG_TONE_EN:   c_tone  = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_run(in_tdata, in_tuser);
    end
    fail_count    <= mismatches;
    pending_count <= exp_q.size();
    result_count  <= results_seen;
  end

endmodule

>>> tb/keypad_gesture_decoder_tb.sv
// Testbench top of the keypad gesture decoder: key event stimulus, register settings, verdict.
`timescale 1ns / 100ps

module keypad_gesture_decoder_tb;
  import kgd_pkg::*;

  localparam int SEG_COUNT   = 6;
  localparam int SEG_ITEMS   = 72;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE_CYC  = 8;

  localparam logic [4:0] KEY_PWR = 5'b00001;
  localparam logic [4:0] KEY_VUP = 5'b00010;
  localparam logic [4:0] KEY_VDN = 5'b00100;
  localparam logic [4:0] KEY_BCK = 5'b01000;
  localparam logic [4:0] KEY_FWD = 5'b10000;

  typedef struct packed {
    logic [4:0]  mask;
    logic        rep;
    logic        rel;
    logic [31:0] tick;
    logic        playing;
    logic        paused;
    logic        track;
    logic [30:0] elapsed;
    logic [30:0] length;
  } key_event_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic [USER_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count, pending_count, result_count;

  // Stimulus bookkeeping.
  int          send_idle_pct = 0;
  int          recv_idle_pct;
  int          hold_reqs;
  int          holds_done = 0;
  int          hold_left  = 0;
  int          items_sent = 0;
  int          settings_done = 0;
  logic [31:0] tick_now;
  logic        st_playing, st_paused, st_track;
  logic [30:0] st_elapsed, st_length;

  keypad_gesture_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  keypad_gesture_decoder_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  // Clock, 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_done != hold_reqs) begin
      out_tready <= 1'b0;
      hold_left  <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one key event, idling at random first, and waits until it is taken.
  task automatic send_event(input key_event_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, e.length, e.elapsed, e.track, e.paused, e.playing, e.tick, e.mask};
    in_tuser  <= {e.rel, e.rep};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Key event at the current playback status, dt ticks after the previous one.
  task automatic send_key(input logic [4:0] mask, input bit rep, input bit rel, input int dt);
    key_event_t e;
    tick_now  = tick_now + dt;
    e.mask    = mask;
    e.rep     = rep;
    e.rel     = rel;
    e.tick    = tick_now;
    e.playing = st_playing;
    e.paused  = st_paused;
    e.track   = st_track;
    e.elapsed = st_elapsed;
    e.length  = st_length;
    send_event(e);
  endtask

  // Writes one register; cfg_valid stays high for the caller to lower.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_setting(input logic cont, input logic [3:0] secs, input logic click,
                               input logic tone);
    write_reg(CFG_SKIP_CONT, {3'b000, cont});
    write_reg(CFG_SKIP_SECS, secs);
    write_reg(CFG_CLICK_EN, {3'b000, click});
    write_reg(CFG_TONE_EN, {3'b000, tone});
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // Stops offering and waits until every predicted item has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Main stimulus.
  initial begin
    int seg_end, kind, n, p, i, directed;
    logic [4:0] m;
    key_event_t e;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_SKIP_CONT;
    cfg_data   <= '0;
    recv_idle_pct <= 0;
    hold_reqs     <= 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events under the reset register values, crossing the tick wrap.
    tick_now   = 32'hFFFF_FFF0;
    st_playing = 1'b1;
    st_paused  = 1'b0;
    st_track   = 1'b1;
    st_elapsed = 31'd3000;
    st_length  = '0;
    send_key(5'b00000, 0, 0, 1);           // no key
    send_key(KEY_VUP | KEY_VDN, 0, 0, 1);  // both volume keys
    send_key(KEY_PWR, 0, 0, 1);
    send_key(KEY_PWR, 0, 0, 5);            // press while already held
    send_key(KEY_PWR, 1, 0, 125);          // falling tones, then lock
    send_key(KEY_PWR, 0, 1, 5);
    send_key(KEY_VUP, 0, 0, 5);            // swallowed while locked
    send_key(KEY_PWR, 0, 0, 5);
    send_key(KEY_PWR, 1, 0, 120);          // rising tones, then unlock
    send_key(KEY_PWR, 1, 0, 300);          // power-off hold
    send_key(KEY_PWR, 1, 0, 10);           // power-off again on the next repeat
    send_key(KEY_PWR, 0, 1, 5);
    st_paused = 1'b1;
    send_key(KEY_PWR, 0, 0, 5);
    send_key(KEY_PWR, 0, 1, 10);           // tap resumes
    st_paused = 1'b0;
    send_key(KEY_PWR, 0, 0, 5);
    send_key(KEY_PWR, 0, 1, -1000);        // time going back still counts as a tap
    send_key(KEY_VUP, 0, 0, 5);
    send_key(KEY_VUP, 1, 0, 30);           // first autorepeat step
    send_key(KEY_VUP, 0, 1, 3);
    send_key(KEY_VDN, 0, 0, 5);
    send_key(KEY_BCK, 0, 0, 5);            // seek clamps at zero
    send_key(KEY_BCK, 1, 0, 35);           // hold changes track and breaks the chain
    send_key(KEY_BCK, 0, 1, 2);
    st_elapsed = 31'h7FFF_FFFF;
    send_key(KEY_FWD, 0, 0, 5);            // unknown length saturates the target
    st_length = 31'd1000;
    send_key(KEY_FWD, 0, 1, 2);
    send_key(KEY_FWD, 0, 0, 5);            // chained, clamped to the track length
    st_playing = 1'b0;
    send_key(KEY_FWD, 0, 0, 5);            // seek refused when not playing
    directed = items_sent;
    drain();

    // Random part: gesture sequences with random content plus some noise.
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg)
        0: apply_setting(1'b0, 4'd3, 1'b1, 1'b1);
        1: apply_setting(1'b1, 4'd0, 1'b0, 1'b0);
        2: apply_setting(1'b1, 4'd15, 1'b1, 1'b1);
        3: apply_setting(1'b0, 4'd15, 1'b0, 1'b1);
        4: apply_setting(1'b1, 4'd1, 1'b1, 1'b0);
        default: apply_setting($urandom_range(1), $urandom_range(15), $urandom_range(1),
                               $urandom_range(1));
      endcase
      if (seg < 2) begin
        send_idle_pct = 9;
        recv_idle_pct <= 58;
      end else if (seg < 4) begin
        send_idle_pct = 58;
        recv_idle_pct <= 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      // Long receiver hold-off while events keep coming, to back up the pipeline.
      if (seg == 4) hold_reqs <= hold_reqs + 1;
      seg_end = items_sent + SEG_ITEMS;
      while (items_sent < seg_end) begin
        st_playing = ($urandom_range(3) != 0);
        st_paused  = ($urandom_range(2) == 0);
        st_track   = ($urandom_range(4) != 0);
        case ($urandom_range(3))
          0: st_elapsed = '0;
          1: st_elapsed = $urandom_range(20000);
          2: st_elapsed = $urandom;
          default: st_elapsed = 31'h7FFF_FFFF - $urandom_range(3000);
        endcase
        case ($urandom_range(3))
          0: st_length = '0;
          1: st_length = st_elapsed + $urandom_range(8000);
          2: st_length = $urandom;
          default: st_length = 31'h7FFF_FFFF;
        endcase
        if ($urandom_range(7) == 0) tick_now = $urandom;
        else if ($urandom_range(15) == 0) tick_now = 32'hFFFF_FFFF - $urandom_range(300);
        kind = $urandom_range(99);
        if (kind < 25) begin
          // Power gesture: press, some repeats, release.
          m = ($urandom_range(4) == 0) ? (KEY_PWR | 5'($urandom_range(15) << 1)) : KEY_PWR;
          n = $urandom_range(8);
          send_key(m, 0, 0, $urandom_range(1, 50));
          if ($urandom_range(4) == 0) send_key(m, 0, 0, $urandom_range(1, 10));
          for (i = 0; i < n; i++)
            send_key(m, 1, 0, ($urandom_range(3) == 0) ? $urandom_range(60, 250)
                                                       : $urandom_range(5, 40));
          if ($urandom_range(9) == 0) send_key(m, 0, 1, -int'($urandom_range(1, 500)));
          else send_key(m, 0, 1, (n == 0) ? $urandom_range(0, 40) : $urandom_range(1, 30));
        end else if (kind < 45) begin
          // Volume press with autorepeat.
          m = $urandom_range(1) ? KEY_VUP : KEY_VDN;
          if ($urandom_range(5) == 0) m = m | 5'($urandom_range(3) << 3);
          n = $urandom_range(10);
          send_key(m, 0, 0, $urandom_range(1, 100));
          for (i = 0; i < n; i++) send_key(m, 1, 0, $urandom_range(1, 12));
          send_key(m, 0, 1, $urandom_range(1, 10));
        end else if (kind < 80) begin
          // Skip key: chains of seek presses, holds that change track.
          m = $urandom_range(1) ? KEY_BCK : KEY_FWD;
          if (m == KEY_BCK && $urandom_range(4) == 0) m = m | KEY_FWD;
          for (p = $urandom_range(1, 3); p > 0; p--) begin
            send_key(m, 0, 0, $urandom_range(5, 250));
            n = $urandom_range(6);
            for (i = 0; i < n; i++)
              send_key(m, 1, 0, ($urandom_range(3) == 0) ? $urandom_range(100, 1600)
                                                         : $urandom_range(5, 30));
            send_key(m, 0, 1, $urandom_range(1, 20));
          end
        end else begin
          // Noise: fully random events.
          for (p = $urandom_range(1, 3); p > 0; p--) begin
            e.mask    = $urandom;
            e.rep     = $urandom;
            e.rel     = $urandom;
            e.tick    = $urandom_range(1) ? $urandom : tick_now + $urandom_range(200);
            e.playing = $urandom;
            e.paused  = $urandom;
            e.track   = $urandom;
            e.elapsed = $urandom;
            e.length  = $urandom;
            tick_now  = e.tick;
            send_event(e);
          end
        end
      end
      drain();
    end

    $display("Sent %0d key events (%0d directed) over %0d register settings;",
             items_sent, directed, settings_done);
    $display("compared %0d command items, including a %0d-cycle receiver hold-off.",
             result_count, LONG_HOLD);
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
